@@ src/ncrd_pkg.sv @@
package ncrd_pkg;

  localparam int unsigned DefMaxWidth  = 256;
  localparam int unsigned DefMaxHeight = 256;
  localparam int unsigned DefGrayLevels = 256;

  localparam int unsigned FieldW = 8;
  localparam int unsigned CfgW   = 9;
  localparam int unsigned DistW  = 17;
  localparam int unsigned CountW = 9;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 48;

  typedef enum logic [1:0] {
    CmdLoad  = 2'd0,
    CmdQuery = 2'd1,
    CmdClear = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    RegWidth  = 2'd0,
    RegHeight = 2'd1
  } cfg_reg_e;

endpackage

@@ src/nearest_color_row_distance.sv @@
// Load: writes the pixel and its row bitmap. Clear: clears the color bitmap and row valid
// bits. Query: a palette rank scan over GRAY_LEVELS gray levels, a read and check of each
// row bitmap visited on the upward and downward walks, and a scan of each of the two rows
// across the width. The pixel memory port sets the scan time. One item at a time.
// Reset (asynchronous, active low) clears the row valid bits and the color bitmap;
// the pixel memory holds no defined value until written.
module nearest_color_row_distance
  import ncrd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH   = DefMaxWidth,
  parameter int unsigned MAX_HEIGHT  = DefMaxHeight,
  parameter int unsigned GRAY_LEVELS = DefGrayLevels
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // col [7:0], row [15:8], gray [23:16], palette_index [31:24]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // cmd [1:0]
  input  logic [1:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // distance [16:0], pixel_value [24:17], color_value [32:25], color_count [41:33],
  // index_valid [42], zero [47:43]
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [CfgW-1:0]     cfg_data_i
);

  localparam int unsigned HW  = $clog2(MAX_HEIGHT);
  localparam int unsigned AW  = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int unsigned GW  = $clog2(GRAY_LEVELS);
  localparam int unsigned GCW = $clog2(GRAY_LEVELS + 1);

  typedef enum logic [10:0] {
    StIdle  = 11'b00000000001,
    StLdWr  = 11'b00000000010,
    StRank  = 11'b00000000100,
    StPix   = 11'b00000001000,
    StPixD  = 11'b00000010000,
    StUpRd  = 11'b00000100000,
    StUpCk  = 11'b00001000000,
    StDnRd  = 11'b00010000000,
    StDnCk  = 11'b00100000000,
    StScan  = 11'b01000000000,
    StDone  = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  logic [CfgW-1:0] cfg_w_q, cfg_h_q;
  logic [CfgW-1:0] eff_w, eff_h;

  logic [FieldW-1:0] col_q, row_q, gray_q, pidx_q;
  logic [GRAY_LEVELS-1:0] seen_q;
  logic [MAX_HEIGHT-1:0]  row_vld_q;

  logic [GCW-1:0]    g_q;
  logic [CountW-1:0] count_q;
  logic [FieldW-1:0] color_q;
  logic              valid_q;
  logic [FieldW-1:0] pix_q;
  logic [DistW-1:0]  none_q, best_q;
  logic [CfgW-1:0]   up_q, dn_q, srow_q, xx_q, px_q;
  logic              pass_q, pv_q;

  logic [OutDataW-1:0] out_q;
  logic                out_vld_q;

  logic              bm_we, px_we;
  logic [HW-1:0]     bm_addr;
  logic [AW-1:0]     px_addr;
  logic [GRAY_LEVELS-1:0] bm_wdata, bm_rdata;
  logic [FieldW-1:0] px_rdata;

  logic              in_image, bm_hit, in_fire;
  logic [CfgW-1:0]   dy, dx, dd;

  always_comb begin
    if (cfg_w_q == '0) eff_w = CfgW'(1);
    else if (int'(cfg_w_q) > MAX_WIDTH) eff_w = CfgW'(MAX_WIDTH);
    else eff_w = cfg_w_q;
    if (cfg_h_q == '0) eff_h = CfgW'(1);
    else if (int'(cfg_h_q) > MAX_HEIGHT) eff_h = CfgW'(MAX_HEIGHT);
    else eff_h = cfg_h_q;
  end

  function automatic logic [AW-1:0] pix_at(logic [CfgW-1:0] r, logic [CfgW-1:0] x);
    return AW'(int'(r) * MAX_WIDTH + int'(x));
  endfunction

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == StIdle);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  assign in_image = ({1'b0, col_q} < eff_w) && ({1'b0, row_q} < eff_h);
  assign bm_hit = (state_q == StUpCk) ? row_vld_q[HW'(up_q)] && bm_rdata[GW'(color_q)]
                                      : row_vld_q[HW'(dn_q)] && bm_rdata[GW'(color_q)];

  assign dy = (srow_q >= {1'b0, row_q}) ? srow_q - {1'b0, row_q} : {1'b0, row_q} - srow_q;
  assign dx = (px_q >= {1'b0, col_q}) ? px_q - {1'b0, col_q} : {1'b0, col_q} - px_q;
  assign dd = (dx > dy) ? dx : dy;

  // Memory address and write control follow the state.
  always_comb begin
    bm_we    = 1'b0;
    px_we    = 1'b0;
    bm_addr  = HW'(s_axis_tdata[15:8]);
    px_addr  = pix_at({1'b0, row_q}, {1'b0, col_q});
    bm_wdata = (row_vld_q[HW'(row_q)] ? bm_rdata : '0)
             | ({{(GRAY_LEVELS-1){1'b0}}, 1'b1} << gray_q);
    unique case (state_q)
      StLdWr: begin
        bm_we   = 1'b1;
        px_we   = 1'b1;
        bm_addr = HW'(row_q);
      end
      StUpRd, StUpCk: bm_addr = HW'(up_q);
      StDnRd, StDnCk: bm_addr = HW'(dn_q);
      StScan: px_addr = pix_at(srow_q, xx_q);
      default: ;
    endcase
  end

  ncrd_ram #(.Width(GRAY_LEVELS), .Depth(MAX_HEIGHT)) u_row_bits (
    .clk_i   (clk_i),
    .we_i    (bm_we),
    .addr_i  (bm_addr),
    .wdata_i (bm_wdata),
    .rdata_o (bm_rdata)
  );

  ncrd_ram #(.Width(FieldW), .Depth(MAX_WIDTH * MAX_HEIGHT)) u_pixels (
    .clk_i   (clk_i),
    .we_i    (px_we),
    .addr_i  (px_addr),
    .wdata_i (gray_q),
    .rdata_o (px_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= CfgW'(256);
      cfg_h_q <= CfgW'(256);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegWidth:  cfg_w_q <= cfg_data_i;
        RegHeight: cfg_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      seen_q    <= '0;
      row_vld_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (m_axis_tready && state_q != StDone) out_vld_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (in_fire) begin
            case (s_axis_tuser)
              CmdLoad: begin
                if ({1'b0, s_axis_tdata[7:0]} < eff_w && {1'b0, s_axis_tdata[15:8]} < eff_h
                    && int'(s_axis_tdata[23:16]) < GRAY_LEVELS) begin
                  state_q <= StLdWr;
                end
              end
              CmdQuery: state_q <= StRank;
              CmdClear: begin
                seen_q    <= '0;
                row_vld_q <= '0;
              end
              default: ;
            endcase
          end
        end
        StLdWr: begin
          seen_q[GW'(gray_q)]   <= 1'b1;
          row_vld_q[HW'(row_q)] <= 1'b1;
          state_q <= StIdle;
        end
        StRank: if (g_q == GCW'(GRAY_LEVELS - 1)) state_q <= StPix;
        StPix:  state_q <= StPixD;
        StPixD: state_q <= (in_image && valid_q) ? StUpRd : StDone;
        StUpRd: state_q <= StUpCk;
        StUpCk: state_q <= (bm_hit || up_q <= CfgW'(1)) ? StDnRd : StUpRd;
        StDnRd: state_q <= StDnCk;
        StDnCk: begin
          if (bm_hit || ({1'b0, dn_q} + 10'd1 >= {1'b0, eff_h} - 10'd1)) state_q <= StScan;
          else state_q <= StDnRd;
        end
        StScan: begin
          if (xx_q == eff_w && !pv_q && pass_q) state_q <= StDone;
        end
        StDone: begin
          if (!out_vld_q || m_axis_tready) begin
            out_vld_q <= 1'b1;
            state_q   <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        col_q   <= s_axis_tdata[7:0];
        row_q   <= s_axis_tdata[15:8];
        gray_q  <= s_axis_tdata[23:16];
        pidx_q  <= s_axis_tdata[31:24];
        g_q     <= '0;
        count_q <= '0;
        color_q <= '0;
        valid_q <= 1'b0;
        none_q  <= DistW'(eff_w) * DistW'(eff_h);
      end
      StRank: begin
        if (seen_q[GW'(g_q)]) begin
          if ({1'b0, pidx_q} == count_q) begin
            color_q <= FieldW'(g_q);
            valid_q <= 1'b1;
          end
          count_q <= count_q + CountW'(1);
        end
        g_q <= g_q + GCW'(1);
      end
      StPixD: begin
        pix_q  <= in_image ? px_rdata : '0;
        best_q <= none_q;
        up_q   <= {1'b0, row_q};
        dn_q   <= {1'b0, row_q};
      end
      StUpCk: begin
        if (!bm_hit) up_q <= (up_q <= CfgW'(1)) ? '0 : up_q - CfgW'(1);
      end
      StDnCk: begin
        if (!bm_hit) begin
          if ({1'b0, dn_q} + 10'd1 >= {1'b0, eff_h} - 10'd1) dn_q <= eff_h - CfgW'(1);
          else dn_q <= dn_q + CfgW'(1);
        end
        srow_q <= up_q;
        xx_q   <= '0;
        pv_q   <= 1'b0;
        pass_q <= 1'b0;
      end
      StScan: begin
        pv_q <= (xx_q != eff_w);
        px_q <= xx_q;
        if (xx_q != eff_w) xx_q <= xx_q + CfgW'(1);
        if (pv_q && px_rdata == color_q && dd != '0 && DistW'(dd) < best_q) begin
          best_q <= DistW'(dd);
        end
        if (xx_q == eff_w && !pv_q && !pass_q) begin
          pass_q <= 1'b1;
          srow_q <= dn_q;
          xx_q   <= '0;
        end
      end
      StDone: begin
        if (!out_vld_q || m_axis_tready) begin
          out_q <= {5'd0, valid_q, count_q, color_q, pix_q,
                    (in_image && valid_q) ? best_q : none_q};
        end
      end
      default: ;
    endcase
  end

endmodule

@@ src/ncrd_ram.sv @@
module ncrd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

@@ tb/nearest_color_row_distance_checker.sv @@
`timescale 1ns / 1ps

module nearest_color_row_distance_checker
  import ncrd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic [1:0]          s_axis_tuser,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  output int                  mismatch_count,
  output int                  awaited_count,
  output int                  queries_checked
);

  typedef struct packed {
    logic [4:0]        zero;
    logic              index_valid;
    logic [CountW-1:0] color_count;
    logic [7:0]        color_value;
    logic [7:0]        pixel_value;
    logic [DistW-1:0]  distance;
  } answer_t;

  logic [7:0]   gray_mem [65536];
  logic [255:0] row_hues [256];
  logic [255:0] hue_seen;
  int unsigned  width_reg, height_reg;
  answer_t      answers_due [$];

  assign awaited_count = answers_due.size();

  function automatic int unsigned clamp_size(int unsigned v);
    if (v == 0) return 1;
    if (v > 256) return 256;
    return v;
  endfunction

  // Smallest nonzero Chebyshev distance from (x,y) to a pixel of hue c in row r.
  function automatic int unsigned nearest_in_row(int unsigned r, int unsigned x,
                                                 int unsigned y, int unsigned c,
                                                 int unsigned w, int unsigned none);
    int unsigned best, dy, dx, d;
    best = none;
    dy = (r >= y) ? r - y : y - r;
    for (int unsigned xx = 0; xx < w; xx++) begin
      if (gray_mem[r * 256 + xx] == c) begin
        dx = (xx >= x) ? xx - x : x - xx;
        d = (dx > dy) ? dx : dy;
        if (d != 0 && d < best) best = d;
      end
    end
    return best;
  endfunction

  function automatic answer_t predict_query(int unsigned col, int unsigned row,
                                            int unsigned rank);
    answer_t     a;
    int unsigned w, h, none, cnt, hue, up, dn, mu, ml;
    logic        found, in_image;
    w = clamp_size(width_reg);
    h = clamp_size(height_reg);
    none = w * h;
    cnt = 0;
    hue = 0;
    found = 1'b0;
    in_image = (col < w) && (row < h);
    a = '0;
    for (int unsigned g = 0; g < 256; g++) begin
      if (hue_seen[g]) begin
        if (cnt == rank) begin
          hue = g;
          found = 1'b1;
        end
        cnt++;
      end
    end
    a.distance = none[DistW-1:0];
    if (in_image) a.pixel_value = gray_mem[row * 256 + col];
    if (in_image && found) begin
      up = row;
      dn = row;
      while (!row_hues[up][hue]) begin
        if (up <= 1) begin
          up = 0;
          break;
        end
        up--;
      end
      while (!row_hues[dn][hue]) begin
        if (dn + 1 >= h - 1) begin
          dn = h - 1;
          break;
        end
        dn++;
      end
      mu = nearest_in_row(up, col, row, hue, w, none);
      ml = nearest_in_row(dn, col, row, hue, w, none);
      mu = (mu < ml) ? mu : ml;
      a.distance = mu[DistW-1:0];
    end
    a.color_value = hue[7:0];
    a.color_count = cnt[CountW-1:0];
    a.index_valid = found;
    return a;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t     want, got;
    int unsigned col, row, gray;
    if (!rst_ni) begin
      width_reg  <= 256;
      height_reg <= 256;
      hue_seen   <= '0;
      for (int i = 0; i < 256; i++) row_hues[i] <= '0;
      answers_due.delete();
      mismatch_count  <= 0;
      queries_checked <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == RegWidth) width_reg <= cfg_data_i;
        else if (cfg_index_i == RegHeight) height_reg <= cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        col  = s_axis_tdata[7:0];
        row  = s_axis_tdata[15:8];
        gray = s_axis_tdata[23:16];
        case (s_axis_tuser)
          CmdLoad: begin
            if (col < clamp_size(width_reg) && row < clamp_size(height_reg)) begin
              gray_mem[row * 256 + col] = gray[7:0];
              row_hues[row][gray] <= 1'b1;
              hue_seen[gray] <= 1'b1;
            end
          end
          CmdClear: begin
            hue_seen <= '0;
            for (int i = 0; i < 256; i++) row_hues[i] <= '0;
          end
          CmdQuery: answers_due = {answers_due, predict_query(col, row, s_axis_tdata[31:24])};
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (answers_due.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10) $display("ERROR: unexpected result %h", got);
        end else begin
          want = answers_due.pop_front();
          queries_checked <= queries_checked + 1;
          if (want.distance !== got.distance || want.pixel_value !== got.pixel_value ||
              want.color_value !== got.color_value ||
              want.color_count !== got.color_count ||
              want.index_valid !== got.index_valid || got.zero !== '0) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10) begin
              $display("ERROR: dist %0d/%0d pix %0d/%0d color %0d/%0d count %0d/%0d",
                       want.distance, got.distance, want.pixel_value, got.pixel_value,
                       want.color_value, got.color_value, want.color_count,
                       got.color_count);
              $display("       valid %0d/%0d pad %h (expected/actual)",
                       want.index_valid, got.index_valid, got.zero);
            end
          end
        end
      end
    end
  end

endmodule

@@ tb/nearest_color_row_distance_test.sv @@
`timescale 1ns / 1ps

module nearest_color_row_distance_test;
  import ncrd_pkg::*;

  localparam logic [1:0] CmdUnused = 2'd3;
  localparam int StallLimit = 50000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [1:0]          s_axis_tuser = CmdLoad;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [1:0]          cfg_index_i = RegWidth;
  logic [CfgW-1:0]     cfg_data_i = '0;

  int          mismatch_count, awaited_count, queries_checked;
  int          send_idle_pct, recv_idle_pct, quiet_cycles;
  int unsigned img_w, img_h, hue_pool [4];
  logic [255:0] hues_loaded;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  nearest_color_row_distance dut (.*);

  nearest_color_row_distance_checker checker_inst (.*);

  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == StallLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_item(logic [1:0] cmd, int unsigned col, int unsigned row,
                           int unsigned gray, int unsigned rank);
    cfg_valid_i <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {rank[7:0], gray[7:0], row[7:0], col[7:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    if (cmd == CmdLoad && col < img_w && row < img_h) hues_loaded[gray[7:0]] = 1'b1;
    if (cmd == CmdClear) hues_loaded = '0;
  endtask

  task automatic write_reg(cfg_reg_e idx, int unsigned value);
    s_axis_tvalid <= 1'b0;
    cfg_valid_i   <= 1'b1;
    cfg_index_i   <= idx;
    cfg_data_i    <= value[CfgW-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  // Loads and clears produce no result, so a short pause covers their tail.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    cfg_valid_i   <= 1'b0;
    while (awaited_count != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  // Every pixel in use gets written after a clear so queries never read an empty entry.
  task automatic start_image(int unsigned w_reg, int unsigned h_reg);
    drain();
    write_reg(RegWidth, w_reg);
    write_reg(RegHeight, h_reg);
    img_w = (w_reg == 0) ? 1 : (w_reg > 256) ? 256 : w_reg;
    img_h = (h_reg == 0) ? 1 : (h_reg > 256) ? 256 : h_reg;
    send_item(CmdClear, 0, 0, 0, 0);
    for (int i = 0; i < 4; i++) hue_pool[i] = $urandom_range(255);
    for (int unsigned r = 0; r < img_h; r++)
      for (int unsigned c = 0; c < img_w; c++)
        send_item(CmdLoad, c, r, hue_pool[$urandom_range(3)], 0);
  endtask

  function automatic int unsigned hue_count();
    int unsigned n;
    n = 0;
    for (int g = 0; g < 256; g++) n += hues_loaded[g];
    return n;
  endfunction

  task automatic random_items(int n);
    int unsigned pick, col, row, gray, rank;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      col = (pick % 7 == 0) ? $urandom_range(255) : $urandom_range(img_w - 1);
      row = (pick % 5 == 0) ? $urandom_range(255) : $urandom_range(img_h - 1);
      gray = ($urandom_range(3) == 0) ? $urandom_range(255) : hue_pool[$urandom_range(3)];
      rank = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(hue_count());
      if (pick < 35) send_item(CmdLoad, col, row, gray, rank);
      else if (pick < 92) send_item(CmdQuery, col, row, gray, rank);
      else send_item(CmdUnused, col, row, gray, rank);
    end
  endtask

  initial begin
    int unsigned sizes [6][2];
    hues_loaded = '0;
    img_w = 256;
    img_h = 256;
    send_idle_pct = 38;
    recv_idle_pct = 64;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Single-pixel image: self match is skipped, edge queries fall outside.
    drain();
    write_reg(RegWidth, 1);
    write_reg(RegHeight, 1);
    img_w = 1;
    img_h = 1;
    send_item(CmdClear, 0, 0, 0, 0);
    send_item(CmdQuery, 255, 255, 0, 0);
    send_item(CmdQuery, 1, 0, 255, 255);
    send_item(CmdLoad, 0, 0, 255, 0);
    send_item(CmdLoad, 5, 0, 7, 0);
    send_item(CmdLoad, 0, 255, 9, 0);
    send_item(CmdQuery, 0, 0, 0, 0);
    send_item(CmdQuery, 0, 0, 0, 1);
    send_item(CmdQuery, 0, 0, 0, 255);
    send_item(CmdUnused, 255, 255, 255, 255);
    send_item(CmdLoad, 0, 0, 0, 0);
    send_item(CmdQuery, 0, 0, 0, 0);
    send_item(CmdQuery, 0, 0, 0, 1);
    send_item(CmdQuery, 0, 0, 0, 2);

    sizes = '{'{0, 3}, '{300, 1}, '{5, 7}, '{12, 9}, '{2, 20}, '{3, 0}};
    for (int p = 0; p < 6; p++) begin
      send_idle_pct = (p < 2) ? 38 : (p < 4) ? 64 : 0;
      recv_idle_pct = (p < 2) ? 64 : (p < 4) ? 38 : 0;
      start_image(sizes[p][0], sizes[p][1]);
      send_item(CmdQuery, img_w - 1, img_h - 1, 0, 0);
      send_item(CmdQuery, 0, 0, 0, 255);
      random_items(17);
    end

    drain();
    $display("Checked %0d query results over six image sizes and one single-pixel case,",
             queries_checked);
    $display("with loads, ignored loads, unknown commands and stalls on both channels.");
    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_count, awaited_count);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/ncrd_pkg.sv
src/ncrd_ram.sv
src/nearest_color_row_distance.sv
tb/nearest_color_row_distance_checker.sv
tb/nearest_color_row_distance_test.sv
